// File: hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int DEF_MAX_COLUMNS = 80;
   localparam int DEF_MAX_ROWS    = 25;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int ATTR_W = 16;
   localparam int CHAR_W = 8;
   localparam int IDX_W  = 11;
   localparam int MAC_W  = COL_W + ROW_W + 1;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [1:0] REG_COLUMNS   = 2'd0;
   localparam logic [1:0] REG_ROWS      = 2'd1;
   localparam logic [1:0] REG_ATTRIBUTE = 2'd2;

   localparam logic [COL_W-1:0]  COLUMNS_RESET   = 7'd80;
   localparam logic [ROW_W-1:0]  ROWS_RESET      = 5'd25;
   localparam logic [ATTR_W-1:0] ATTRIBUTE_RESET = 16'h0700;

   // request to the shared multiply-add unit: a * b + c
   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] a;
      logic [ROW_W-1:0] b;
      logic [COL_W-1:0] c;
   } mac_req_type;

endpackage

// File: hw/rtl/tcw_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_mac
// Shared multiply-add unit with a registered result, used for cell
// addresses and for the size of the scroll region.
// ----------------------------------------------------------------------------
module tcw_mac import tcw_pkg::*; (
   input  logic             clock,
   input  mac_req_type      req,
   output logic [MAC_W-1:0] res
);

   logic [MAC_W-1:0] res_ff;
   logic [MAC_W-1:0] res_in;

   assign res_in = MAC_W'(MAC_W'(req.a) * MAC_W'(req.b)) + MAC_W'(req.c);

   always_ff @(posedge clock) begin
      if (req.en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// File: hw/rtl/tcw_cell_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Character cell store: one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_cell_ram import tcw_pkg::*; #(
   parameter int DEPTH  = DEF_MAX_COLUMNS * DEF_MAX_ROWS,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [ATTR_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [ATTR_W-1:0] rdata
);

   logic [ATTR_W-1:0] cells_ff [DEPTH];
   logic [ATTR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         cells_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= cells_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: character cell store, cursor, wrap and scroll.
// ----------------------------------------------------------------------------
// Usage
//   Items are issued with start while busy is low: req_op selects a put of
//   req_char_code (10 is a newline) or a read of cell req_cell_index.
//   Each item yields one result, shown for a single cycle with rsp_valid;
//   the receiver cannot stall, so the result must be taken in that cycle.
//   Registers columns, rows and attribute sit on the APB port at 0, 4, 8;
//   the user must write them only while the block is idle (not enforced).
// Sequence
//   A read goes through a wait state for the registered store read. A put
//   asks the shared multiply-add unit for the cell address, then writes it;
//   a newline skips both. A put that scrolls first moves the screen up a row:
//   every moved cell is a read then a write, and the freed row is refilled.
// Reset
//   Cursor and registers return to their reset values, then a clearing
//   pass writes zero to all MAX_COLUMNS*MAX_ROWS cells (2000 by default),
//   during which busy is high.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_op,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [IDX_W-1:0]  req_cell_index,
   output logic              rsp_valid,
   output logic [ATTR_W-1:0] rsp_cell_value,
   output logic [COL_W-1:0]  rsp_cursor_column,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic              rsp_scrolled,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_RD_WAIT  = 4'd2;
   localparam logic [3:0] ST_SC_MUL   = 4'd3;
   localparam logic [3:0] ST_SC_SETUP = 4'd4;
   localparam logic [3:0] ST_SC_RD    = 4'd5;
   localparam logic [3:0] ST_SC_WR    = 4'd6;
   localparam logic [3:0] ST_PUT_MUL  = 4'd7;
   localparam logic [3:0] ST_PUT_WR   = 4'd8;

   // configuration registers
   logic [COL_W-1:0]  columns_ff;
   logic [ROW_W-1:0]  rows_ff;
   logic [ATTR_W-1:0] attribute_ff;
   logic              csr_write;

   // sequencer
   logic [3:0]        state_ff,   state_in;
   logic [CNT_W-1:0]  cnt_ff,     cnt_in;
   logic [CNT_W-1:0]  moved_ff,   moved_in;
   logic [CNT_W-1:0]  total_ff,   total_in;
   logic [COL_W-1:0]  col_ff,     col_in;
   logic [ROW_W-1:0]  line_ff,    line_in;
   logic [CHAR_W-1:0] chr_ff,     chr_in;
   logic              write_ff,   write_in;
   logic              scroll_ff,  scroll_in;
   logic              rd_oob_ff,  rd_oob_in;

   // result registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ATTR_W-1:0] rsp_value_ff, rsp_value_in;
   logic [COL_W-1:0]  rsp_col_ff,   rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff,   rsp_row_in;
   logic              rsp_scr_ff,   rsp_scr_in;

   // effective geometry and cursor update
   logic [COL_W-1:0]  ncol;
   logic [ROW_W-1:0]  nrow;
   logic [ROW_W-1:0]  line_c;
   logic              wrap;
   logic              last_row;

   // store and shared unit
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ATTR_W-1:0] ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [ATTR_W-1:0] ram_rdata;
   mac_req_type       mac_req;
   logic [MAC_W-1:0]  mac_res;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
         attribute_ff <= ATTRIBUTE_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_COLUMNS:   columns_ff   <= pwdata[COL_W-1:0];
            REG_ROWS:      rows_ff      <= pwdata[ROW_W-1:0];
            REG_ATTRIBUTE: attribute_ff <= pwdata[ATTR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_COLUMNS:   prdata = 32'(columns_ff);
         REG_ROWS:      prdata = 32'(rows_ff);
         REG_ATTRIBUTE: prdata = 32'(attribute_ff);
         default:       prdata = 32'd0;
      endcase
   end

   always_comb begin
      if (columns_ff == '0) begin
         ncol = COL_W'(1);
      end else if (32'(columns_ff) > MAX_COLUMNS) begin
         ncol = COL_W'(MAX_COLUMNS);
      end else begin
         ncol = columns_ff;
      end
      if (rows_ff == '0) begin
         nrow = ROW_W'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         nrow = ROW_W'(MAX_ROWS);
      end else begin
         nrow = rows_ff;
      end
   end

   // cursor row pulled back into range, then wrap decision
   assign line_c   = (line_ff >= nrow) ? nrow - ROW_W'(1) : line_ff;
   assign wrap     = (col_ff >= ncol) || (req_char_code == NEWLINE_CODE);
   assign last_row = (line_c == nrow - ROW_W'(1));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      moved_in     = moved_ff;
      total_in     = total_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      chr_in       = chr_ff;
      write_in     = write_ff;
      scroll_in    = scroll_ff;
      rd_oob_in    = rd_oob_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_scr_in   = rsp_scr_ff;
      ram_we       = 1'b0;
      ram_waddr    = ADDR_W'(cnt_ff);
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = ADDR_W'(req_cell_index);
      mac_req      = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_op == OP_READ) begin
                  ram_re    = 1'b1;
                  rd_oob_in = (32'(req_cell_index) >= CELL_COUNT);
                  state_in  = ST_RD_WAIT;
               end else begin
                  chr_in    = req_char_code;
                  write_in  = (req_char_code != NEWLINE_CODE);
                  scroll_in = wrap && last_row;
                  col_in    = wrap ? '0 : col_ff;
                  line_in   = (wrap && !last_row) ? line_c + ROW_W'(1) : line_c;
                  state_in  = (wrap && last_row) ? ST_SC_MUL : ST_PUT_MUL;
               end
            end
         end
         ST_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_oob_ff ? '0 : ram_rdata;
            rsp_col_in   = col_ff;
            rsp_row_in   = line_ff;
            rsp_scr_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_SC_MUL: begin
            // moved cells = columns * (rows - 1)
            mac_req.en = 1'b1;
            mac_req.a  = ncol;
            mac_req.b  = nrow - ROW_W'(1);
            mac_req.c  = '0;
            state_in   = ST_SC_SETUP;
         end
         ST_SC_SETUP: begin
            moved_in = CNT_W'(mac_res);
            total_in = CNT_W'(mac_res) + CNT_W'(ncol);
            cnt_in   = '0;
            state_in = ST_SC_RD;
         end
         ST_SC_RD: begin
            if (cnt_ff < moved_ff) begin
               ram_re    = 1'b1;
               ram_raddr = ADDR_W'(cnt_ff + CNT_W'(ncol));
               state_in  = ST_SC_WR;
            end else if (cnt_ff < total_ff) begin
               // freed bottom row gets the bare attribute
               ram_we    = 1'b1;
               ram_wdata = attribute_ff;
               cnt_in    = cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_PUT_MUL;
            end
         end
         ST_SC_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            cnt_in    = cnt_ff + CNT_W'(1);
            state_in  = ST_SC_RD;
         end
         ST_PUT_MUL: begin
            if (write_ff) begin
               mac_req.en = 1'b1;
               mac_req.a  = ncol;
               mac_req.b  = line_ff;
               mac_req.c  = col_ff;
               state_in   = ST_PUT_WR;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_col_in   = col_ff;
               rsp_row_in   = line_ff;
               rsp_scr_in   = scroll_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_PUT_WR: begin
            ram_we       = 1'b1;
            ram_waddr    = ADDR_W'(mac_res);
            ram_wdata    = ATTR_W'(chr_ff) | attribute_ff;
            col_in       = col_ff + COL_W'(1);
            rsp_valid_in = 1'b1;
            rsp_value_in = '0;
            rsp_col_in   = col_ff + COL_W'(1);
            rsp_row_in   = line_ff;
            rsp_scr_in   = scroll_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         col_ff       <= '0;
         line_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      moved_ff     <= moved_in;
      total_ff     <= total_in;
      chr_ff       <= chr_in;
      write_ff     <= write_in;
      scroll_ff    <= scroll_in;
      rd_oob_ff    <= rd_oob_in;
      rsp_value_ff <= rsp_value_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_scr_ff   <= rsp_scr_in;
   end

   tcw_cell_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W)
   ) u_cell_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tcw_mac u_mac (
      .clock (clock),
      .req   (mac_req),
      .res   (mac_res)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_value    = rsp_value_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_scrolled      = rsp_scr_ff;

endmodule

// File: hw/rtl/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              req_op,
   input logic              rsp_valid,
   input logic [ATTR_W-1:0] rsp_cell_value,
   input logic              rsp_scrolled
);

   // an accepted transfer always occupies the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not raise busy");

   // a result leaves the block ready for the next transfer
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // one result per item, never on consecutive cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // reads answer through the read wait state and the result register
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_READ) |-> ##2 rsp_valid)
      else $error("read result missing");

   // only puts scroll, and puts return no cell value
   a_scroll_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> (rsp_cell_value == '0))
      else $error("scrolling result carries a cell value");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_op         (req_op),
   .rsp_valid      (rsp_valid),
   .rsp_cell_value (rsp_cell_value),
   .rsp_scrolled   (rsp_scrolled)
);

// File: tb/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. A shadow copy of the cell
// store and cursor predicts every result; put and read items are issued on the
// start/busy port with random gaps, and columns, rows and attribute are
// changed over the APB port between phases, extremes and full-size scrolls
// included.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int SCREEN_COLS = DEF_MAX_COLUMNS;
   localparam int SCREEN_ROWS = DEF_MAX_ROWS;
   localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
   localparam int ITEM_TARGET = 1750;
   localparam int CALM_TAIL   = 200;

   typedef struct packed {
      logic [ATTR_W-1:0] cell_value;
      logic [COL_W-1:0]  cursor_column;
      logic [ROW_W-1:0]  cursor_row;
      logic              scrolled;
   } console_report_type;

   class console_shadow;
      logic [ATTR_W-1:0]  cells [CELL_COUNT];
      int unsigned        col_pos;
      int unsigned        line_pos;
      logic [COL_W-1:0]   columns;
      logic [ROW_W-1:0]   rows;
      logic [ATTR_W-1:0]  attribute;
      console_report_type awaited_reports [$];
      int                 errors;
      int                 puts;
      int                 reads;
      int                 scrolls;

      function new();
         foreach (cells[i]) cells[i] = '0;
         col_pos   = 0;
         line_pos  = 0;
         columns   = COLUMNS_RESET;
         rows      = ROWS_RESET;
         attribute = ATTRIBUTE_RESET;
         errors    = 0;
         puts      = 0;
         reads     = 0;
         scrolls   = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [31:0] value);
         case (index)
            REG_COLUMNS:   columns   = value[COL_W-1:0];
            REG_ROWS:      rows      = value[ROW_W-1:0];
            REG_ATTRIBUTE: attribute = value[ATTR_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned used_columns();
         if (columns == 0) return 1;
         if (columns > SCREEN_COLS) return SCREEN_COLS;
         return columns;
      endfunction

      function int unsigned used_rows();
         if (rows == 0) return 1;
         if (rows > SCREEN_ROWS) return SCREEN_ROWS;
         return rows;
      endfunction

      // advance the shadow screen by one accepted item
      function void note_item(logic op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
         console_report_type rep;
         int unsigned        ncol;
         int unsigned        nrow;
         int unsigned        addr;
         int unsigned        moved;
         bit                 write_cell;
         rep = '0;
         if (op == OP_READ) begin
            reads++;
            if (idx < CELL_COUNT) rep.cell_value = cells[idx];
         end else begin
            puts++;
            ncol = used_columns();
            nrow = used_rows();
            write_cell = 1'b1;
            if (line_pos >= nrow) line_pos = nrow - 1;
            if (col_pos >= ncol || ch == NEWLINE_CODE) begin
               col_pos = 0;
               line_pos++;
               if (line_pos >= nrow) begin
                  moved = ncol * (nrow - 1);
                  for (int unsigned i = 0; i < moved; i++) cells[i] = cells[i + ncol];
                  for (int unsigned i = 0; i < ncol; i++) cells[moved + i] = attribute;
                  rep.scrolled = 1'b1;
                  scrolls++;
                  line_pos = nrow - 1;
               end
               if (ch == NEWLINE_CODE) write_cell = 1'b0;
            end
            if (write_cell) begin
               addr = col_pos + line_pos * ncol;
               if (addr < CELL_COUNT) cells[addr] = {{(ATTR_W-CHAR_W){1'b0}}, ch} | attribute;
               col_pos++;
            end
         end
         rep.cursor_column = col_pos[COL_W-1:0];
         rep.cursor_row    = line_pos[ROW_W-1:0];
         awaited_reports.push_back(rep);
      endfunction

      function void check_result(console_report_type got);
         console_report_type want;
         if (awaited_reports.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result with none awaited: cell %h col %0d row %0d scr %0b",
                        $realtime, got.cell_value, got.cursor_column, got.cursor_row,
                        got.scrolled);
            return;
         end
         want = awaited_reports.pop_front();
         if (got.cell_value !== want.cell_value || got.cursor_column !== want.cursor_column ||
             got.cursor_row !== want.cursor_row || got.scrolled !== want.scrolled) begin
            errors++;
            if (errors <= 10)
               $display({"%0t: mismatch exp cell %h col %0d row %0d scr %0b,",
                         " got cell %h col %0d row %0d scr %0b"},
                        $realtime, want.cell_value, want.cursor_column, want.cursor_row,
                        want.scrolled, got.cell_value, got.cursor_column, got.cursor_row,
                        got.scrolled);
         end
      endfunction
   endclass

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic              busy;
   logic              req_op         = OP_PUT;
   logic [CHAR_W-1:0] req_char_code  = '0;
   logic [IDX_W-1:0]  req_cell_index = '0;
   logic              rsp_valid;
   logic [ATTR_W-1:0] rsp_cell_value;
   logic [COL_W-1:0]  rsp_cursor_column;
   logic [ROW_W-1:0]  rsp_cursor_row;
   logic              rsp_scrolled;
   logic              psel           = 1'b0;
   logic              penable        = 1'b0;
   logic              pwrite         = 1'b0;
   logic [3:0]        paddr          = '0;
   logic [31:0]       pwdata         = '0;
   logic [31:0]       prdata;
   logic              pready;

   console_shadow shadow;
   int            items_sent  = 0;
   int            idle_pct    = 0;
   int            phase_count = 0;

   text_console_writer u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_char_code     (req_char_code),
      .req_cell_index    (req_cell_index),
      .rsp_valid         (rsp_valid),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_scrolled      (rsp_scrolled),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // results cannot be held off, so every strobe is a transfer
   always @(posedge clock) begin
      console_report_type got;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         got.cell_value    = rsp_cell_value;
         got.cursor_column = rsp_cursor_column;
         got.cursor_row    = rsp_cursor_row;
         got.scrolled      = rsp_scrolled;
         shadow.check_result(got);
      end
   end

   // start stays high here unless a random idle gap lowers it; the drain task lowers it too
   task automatic send_item(logic op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
      start          <= 1'b1;
      req_op         <= op;
      req_char_code  <= ch;
      req_cell_index <= idx;
      do @(posedge clock); while (busy !== 1'b0);
      shadow.note_item(op, ch, idx);
      items_sent++;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (shadow.awaited_reports.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      shadow.set_register(index, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_screen(logic [31:0] cols, logic [31:0] rws, logic [31:0] attr);
      write_reg(REG_COLUMNS, cols);
      write_reg(REG_ROWS, rws);
      write_reg(REG_ATTRIBUTE, attr);
      phase_count++;
   endtask

   // mixed traffic: mostly puts, newlines at nl_pct, reads mostly aimed at the used area
   task automatic run_traffic(int count, int nl_pct, int read_pct);
      logic [CHAR_W-1:0] ch;
      logic [IDX_W-1:0]  idx;
      int unsigned       area;
      for (int n = 0; n < count; n++) begin
         if (items_sent >= ITEM_TARGET - CALM_TAIL) idle_pct = 0;
         if ($urandom_range(0, 99) < read_pct) begin
            area = shadow.used_columns() * shadow.used_rows();
            if ($urandom_range(0, 9) < 7) idx = IDX_W'($urandom_range(0, area - 1));
            else idx = IDX_W'($urandom);
            send_item(OP_READ, CHAR_W'($urandom), idx);
         end else begin
            if ($urandom_range(0, 99) < nl_pct) ch = NEWLINE_CODE;
            else ch = CHAR_W'($urandom);
            send_item(OP_PUT, ch, IDX_W'($urandom));
         end
      end
   endtask

   initial begin
      logic [31:0] cols;
      logic [31:0] rws;
      logic [31:0] attr;
      int          sel;
      int          big_phases;
      bit          big;
      big_phases = 0;
      shadow = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset geometry, empty store, reads beyond the store
      idle_pct = 30;
      send_item(OP_READ, 8'h00, 11'd0);
      send_item(OP_READ, 8'hFF, 11'h7FF);
      send_item(OP_PUT, 8'h00, 11'h7FF);
      send_item(OP_PUT, 8'hFF, 11'd0);
      send_item(OP_PUT, NEWLINE_CODE, 11'd0);
      send_item(OP_READ, 8'h00, 11'd0);
      send_item(OP_READ, 8'h00, 11'd1);
      send_item(OP_READ, 8'h00, 11'd80);
      drain_results();

      // zero columns and rows act as one: cursor pulled back, every wrap scrolls
      set_screen(32'd0, 32'd0, 32'h0000_FFFF);
      send_item(OP_PUT, 8'h41, 11'd0);
      send_item(OP_PUT, 8'h42, 11'd0);
      send_item(OP_PUT, NEWLINE_CODE, 11'd0);
      send_item(OP_READ, 8'h00, 11'd0);
      drain_results();

      // oversized registers clamp to the full screen
      set_screen(32'd127, 32'd31, 32'h0000_0000);
      send_item(OP_PUT, 8'h7F, 11'd0);
      send_item(OP_PUT, 8'h80, 11'd0);
      drain_results();

      // columns lowered below the cursor: pending wrap
      set_screen(32'd1, 32'd31, 32'h0000_1234);
      send_item(OP_PUT, 8'h55, 11'd0);
      send_item(OP_PUT, NEWLINE_CODE, 11'd0);
      send_item(OP_READ, 8'h00, 11'd1999);
      send_item(OP_READ, 8'h00, 11'd1024);
      send_item(OP_READ, 8'h00, 11'd2000);
      drain_results();

      // full screen with many newlines, so the whole store gets scrolled
      set_screen(32'd80, 32'd25, 32'h0000_0700);
      idle_pct = 20;
      run_traffic(70, 50, 10);
      drain_results();
      big_phases++;

      while (items_sent < ITEM_TARGET) begin
         sel  = $urandom_range(0, 9);
         cols = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd127 : (sel == 2) ? 32'd80 :
                32'($urandom_range(1, 20));
         sel  = $urandom_range(0, 9);
         rws  = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd31 : (sel == 2) ? 32'd25 :
                32'($urandom_range(1, 8));
         sel  = $urandom_range(0, 9);
         attr = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF : 32'($urandom_range(0, 16'hFFFF));
         big  = (cols > 20 || cols == 0 ? ((cols == 0) ? 1 : 80) : cols) *
                (rws > 8 || rws == 0 ? ((rws == 0) ? 1 : 25) : rws) > 160;
         if (big && big_phases >= 4) begin
            cols = 32'($urandom_range(1, 20));
            rws  = 32'($urandom_range(1, 8));
            big  = 1'b0;
         end
         if (big) big_phases++;
         set_screen(cols, rws, attr);
         sel = $urandom_range(0, 3);
         idle_pct = (sel == 0) ? 0 : (sel == 1) ? 50 : 25;
         run_traffic(big ? 40 : $urandom_range(60, 120), $urandom_range(5, 40),
                     $urandom_range(10, 35));
         drain_results();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d items (%0d puts, %0d reads) over %0d screen settings",
               items_sent, shadow.puts, shadow.reads, phase_count);
      $display("screen scrolled %0d times, %0d failures", shadow.scrolls, shadow.errors);
      if (shadow.errors == 0 && shadow.awaited_reports.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #72_000_000;
      $display("timeout, %0d results still awaited", shadow.awaited_reports.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_mac.sv
hw/rtl/tcw_cell_ram.sv
hw/rtl/text_console_writer.sv
hw/rtl/tcw_checker.sv
tb/text_console_writer_tb.sv
